// File: rtl/core/ocu_pkg.sv
// shared constants, types and helper functions for the orbit camera update block
// no dependencies; used by ocu_mul, ocu_isqrt and orbit_camera_update_top
package ocu_pkg;

	// number formats
	localparam int FRACTION_BITS = 16;
	localparam int CORDIC_STEPS  = 16;
	localparam int ANG_FRAC      = 24;
	localparam int ANG_SHIFT     = ANG_FRAC - FRACTION_BITS;

	// word widths
	localparam int VW = 33;          // trig values and vectors to normalize
	localparam int MW = 33;          // multiplier operands
	localparam int PW = 2 * MW + 1;  // signed product
	localparam int ZW = 36;          // cordic angle accumulator
	localparam int RW = 40;          // angle reduction
	localparam int QW = 15;          // quotient bits of a normalized component

	// angle constants
	localparam logic [RW-1:0] FULL_TURN = RW'(360) << FRACTION_BITS;
	localparam int RED_RAW   = 33 - $clog2(360 << FRACTION_BITS);
	localparam int RED_STEPS = (RED_RAW > 1) ? RED_RAW : 1;
	localparam logic signed [ZW-1:0] D90  = ZW'(90) << ANG_FRAC;
	localparam logic signed [ZW-1:0] D180 = ZW'(180) << ANG_FRAC;
	localparam logic signed [ZW-1:0] D270 = ZW'(270) << ANG_FRAC;
	localparam logic signed [ZW-1:0] D360 = ZW'(360) << ANG_FRAC;
	localparam logic signed [VW-1:0] CORDIC_X0 = VW'(652032874);

	// rounding offsets
	localparam logic signed [PW-1:0] HALF14 = PW'(1) << 13;
	localparam logic signed [PW-1:0] HALF30 = PW'(1) << 29;

	// saturation bounds
	localparam logic signed [39:0] SAT_HI = 40'sh00_7fff_ffff;
	localparam logic signed [39:0] SAT_LO = -40'sh00_8000_0000;

	// configuration register indexes
	localparam logic [2:0] CFG_START_PITCH   = 3'd0;
	localparam logic [2:0] CFG_START_YAW     = 3'd1;
	localparam logic [2:0] CFG_START_RADIUS  = 3'd2;
	localparam logic [2:0] CFG_START_PIVOT_X = 3'd3;
	localparam logic [2:0] CFG_START_PIVOT_Y = 3'd4;
	localparam logic [2:0] CFG_START_PIVOT_Z = 3'd5;

	typedef enum logic [1:0] {
		OP_ROTATE  = 2'd0,
		OP_STRAFE  = 2'd1,
		OP_RADIUS  = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DST_FWD = 2'd0,
		DST_RGT = 2'd1,
		DST_UP  = 2'd2
	} dst_t;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_APPLY = 13'b0000000000010,
		ST_SMUL  = 13'b0000000000100,
		ST_RED   = 13'b0000000001000,
		ST_FOLD  = 13'b0000000010000,
		ST_CORD  = 13'b0000000100000,
		ST_FMUL  = 13'b0000001000000,
		ST_NSQ   = 13'b0000010000000,
		ST_ROOT  = 13'b0000100000000,
		ST_DIV   = 13'b0001000000000,
		ST_PMUL  = 13'b0010000000000,
		ST_XMUL  = 13'b0100000000000,
		ST_DONE  = 13'b1000000000000
	} state_t;

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic logic [31:0] atan_deg(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd754974720;
			5'd1:  r = 32'd445687602;
			5'd2:  r = 32'd235489088;
			5'd3:  r = 32'd119537938;
			5'd4:  r = 32'd60000934;
			5'd5:  r = 32'd30029717;
			5'd6:  r = 32'd15018523;
			5'd7:  r = 32'd7509720;
			5'd8:  r = 32'd3754917;
			5'd9:  r = 32'd1877466;
			5'd10: r = 32'd938734;
			5'd11: r = 32'd469367;
			5'd12: r = 32'd234684;
			5'd13: r = 32'd117342;
			5'd14: r = 32'd58671;
			5'd15: r = 32'd29335;
			5'd16: r = 32'd14668;
			5'd17: r = 32'd7334;
			5'd18: r = 32'd3667;
			5'd19: r = 32'd1833;
			5'd20: r = 32'd917;
			5'd21: r = 32'd458;
			5'd22: r = 32'd229;
			5'd23: r = 32'd115;
			5'd24: r = 32'd57;
			5'd25: r = 32'd29;
			5'd26: r = 32'd14;
			5'd27: r = 32'd7;
			5'd28: r = 32'd4;
			5'd29: r = 32'd2;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI)
			r = 32'sh7fff_ffff;
		else if (v < SAT_LO)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// magnitude of a signed word
	function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] x);
		logic [MW:0] e;
		e = {x[MW-1], x};
		return x[MW-1] ? MW'(-e) : MW'(e);
	endfunction

endpackage

// File: rtl/core/ocu_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on ocu_pkg
module ocu_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [ocu_pkg::MW-1:0] a,
	input  logic signed [ocu_pkg::MW-1:0] b,
	output logic                         done,
	output logic signed [ocu_pkg::PW-1:0] prod
);
	import ocu_pkg::*;

	logic [MW-1:0]   mcand_q;
	logic [2*MW-1:0] acc_q;
	logic            neg_q;
	logic            busy_q;
	logic            done_q;
	logic [5:0]      cnt_q;
	logic [MW:0]     sum;

	// add the multiplicand into the upper half when the low bit is set
	always_comb begin
		sum = {1'b0, acc_q[2*MW-1:MW]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mag(a);
			acc_q   <= {{MW{1'b0}}, mag(b)};
			neg_q   <= a[MW-1] ^ b[MW-1];
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

// File: rtl/core/ocu_isqrt.sv
// floor integer square root of a 64-bit word, one result bit per cycle
// depends on ocu_pkg
module ocu_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [31:0] root
);
	import ocu_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic        ge;

	always_comb begin
		trial = {1'b0, res_q} + {1'b0, bit_q};
		ge    = {1'b0, rem_q} >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	// one bit pair per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - trial[63:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// File: rtl/core/orbit_camera_update_top.sv
// orbit camera update: top level with sequencer, cordic, divider and state
// depends on ocu_pkg, ocu_mul, ocu_isqrt
//
// An item's run from acceptance to its result is dominated by the single
// bit-serial multiplier, which runs 20 products per item (26 for a strafe);
// the rest is two angle reductions and cordic runs, three square roots and
// nine divisions. Input is taken only while the sequencer is idle; a
// finished result waits in its own output register, so the next item may be
// accepted before it is taken. After reset the block runs one restart pass
// without producing a result, with in_ready low.
module orbit_camera_update_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] delta_a,
	input  logic signed [31:0] delta_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position_x,
	output logic signed [31:0] position_y,
	output logic signed [31:0] position_z,
	output logic signed [15:0] forward_x,
	output logic signed [15:0] forward_y,
	output logic signed [15:0] forward_z,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z
);
	import ocu_pkg::*;

	// control state
	state_t     state_q;
	op_t        op_q;
	dst_t       dst_q;
	logic [2:0] idx_q;
	logic [4:0] cnt_q;
	logic       wait_q;
	logic       ang_sel_q;
	logic       emit_q;
	logic       out_valid_q;

	// configuration
	logic signed [31:0] start_pitch_q, start_yaw_q, start_radius_q;
	logic signed [31:0] start_pivot_x_q, start_pivot_y_q, start_pivot_z_q;

	// camera state
	logic signed [31:0] pitch_q, yaw_q, radius_q;
	logic signed [31:0] piv_q [3];
	logic signed [31:0] delta_a_q, delta_b_q;
	logic signed [15:0] fwd_q [3];
	logic signed [15:0] rgt_q [3];
	logic signed [15:0] up_q [3];
	logic signed [31:0] pos_q [3];

	// work registers
	logic signed [VW-1:0] v_q [3];
	logic signed [VW-1:0] cy_q, sy_q, cp_q, sp_q;
	logic [RW-1:0]        m_q, dv_q;
	logic                 aneg_q;
	logic signed [ZW-1:0] z_q;
	logic signed [VW-1:0] x_q, y_q;
	logic                 fneg_q;
	logic signed [PW-1:0] p1_q;
	logic [63:0]          sum_q;
	logic [31:0]          len_q;
	logic [32:0]          dr_q;
	logic [QW-1:0]        dn_q, quo_q;

	// output register
	logic signed [31:0] out_pos_q [3];
	logic signed [15:0] out_fwd_q [3];
	logic signed [15:0] out_rgt_q [3];
	logic signed [15:0] out_up_q [3];

	// shared units
	logic                 mul_go, mul_done;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic                 root_go, root_done;
	logic [31:0]          root;
	logic                 mul_state;

	// combinational helpers
	logic [1:0]           vi;
	logic signed [31:0]   ang;
	logic [RW-1:0]        mm;
	logic signed [ZW-1:0] z0;
	logic signed [ZW-1:0] atan_z;
	logic signed [VW-1:0] nx, ny;
	logic signed [ZW-1:0] nz;
	logic signed [PW-1:0] str_sum, pm_sum, r30;
	logic signed [31:0]   piv_str, pos_new;
	logic signed [VW-1:0] raw_new;
	logic [47:0]          div_n;
	logic [32:0]          div_t;
	logic                 div_ge;
	logic [QW-1:0]        quo_next;
	logic signed [15:0]   div_res;
	logic                 div_last;
	logic                 out_load;

	ocu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	ocu_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_go),
		.n      (sum_q),
		.done   (root_done),
		.root   (root)
	);

	// unit launch; paired products address one component per pair
	always_comb begin
		mul_state = (state_q == ST_SMUL) || (state_q == ST_FMUL) || (state_q == ST_NSQ) ||
			(state_q == ST_PMUL) || (state_q == ST_XMUL);
		mul_go  = mul_state && !wait_q;
		root_go = (state_q == ST_ROOT) && !wait_q;
		vi      = ((state_q == ST_SMUL) || (state_q == ST_XMUL)) ? idx_q[2:1] : idx_q[1:0];
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SMUL: begin
				if (!idx_q[0]) begin
					mul_a = MW'(delta_a_q);
					mul_b = MW'(rgt_q[vi]);
				end else begin
					mul_a = MW'(delta_b_q);
					mul_b = MW'(up_q[vi]);
				end
			end
			ST_FMUL: begin
				mul_a = idx_q[0] ? sy_q : cy_q;
				mul_b = cp_q;
			end
			ST_NSQ: begin
				mul_a = v_q[vi];
				mul_b = v_q[vi];
			end
			ST_PMUL: begin
				mul_a = MW'(fwd_q[vi]);
				mul_b = MW'(radius_q);
			end
			ST_XMUL: begin
				case (idx_q)
					3'd0: begin mul_a = MW'(rgt_q[1]); mul_b = MW'(fwd_q[2]); end
					3'd1: begin mul_a = MW'(rgt_q[2]); mul_b = MW'(fwd_q[1]); end
					3'd2: begin mul_a = MW'(rgt_q[2]); mul_b = MW'(fwd_q[0]); end
					3'd3: begin mul_a = MW'(rgt_q[0]); mul_b = MW'(fwd_q[2]); end
					3'd4: begin mul_a = MW'(rgt_q[0]); mul_b = MW'(fwd_q[1]); end
					3'd5: begin mul_a = MW'(rgt_q[1]); mul_b = MW'(fwd_q[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product post-processing
	always_comb begin
		str_sum = prod - p1_q + HALF14;
		piv_str = sat32(40'(piv_q[vi]) + 40'(str_sum >>> 14));
		pm_sum  = prod + HALF14;
		pos_new = sat32(40'(piv_q[vi]) - 40'(pm_sum >>> 14));
		r30     = prod + HALF30;
		raw_new = VW'(r30 >>> 30);
	end

	// angle reduction and folding
	always_comb begin
		ang = ang_sel_q ? pitch_q : yaw_q;
		mm  = (aneg_q && (m_q != '0)) ? FULL_TURN - m_q : m_q;
		z0  = ZW'(mm << ANG_SHIFT);
	end

	// cordic rotation step
	always_comb begin
		atan_z = ZW'(atan_deg(cnt_q));
		if (!z_q[ZW-1]) begin
			nx = x_q - (y_q >>> cnt_q);
			ny = y_q + (x_q >>> cnt_q);
			nz = z_q - atan_z;
		end else begin
			nx = x_q + (y_q >>> cnt_q);
			ny = y_q - (x_q >>> cnt_q);
			nz = z_q + atan_z;
		end
	end

	// restoring division step for one normalized component
	always_comb begin
		div_n    = (48'(mag(v_q[vi])) << 14) + 48'(len_q >> 1);
		div_t    = {dr_q[31:0], dn_q[QW-1]};
		div_ge   = div_t >= {1'b0, len_q};
		quo_next = {quo_q[QW-2:0], div_ge};
		if (cnt_q == 5'd0)
			div_res = '0;
		else if (v_q[vi][VW-1])
			div_res = -$signed({1'b0, quo_next});
		else
			div_res = $signed({1'b0, quo_next});
		div_last = ((cnt_q == 5'd0) && (len_q == '0)) || (cnt_q == 5'(QW));
		out_load = (state_q == ST_DONE) && emit_q && (!out_valid_q || out_ready);
	end

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_APPLY;
			op_q            <= OP_RESTART;
			dst_q           <= DST_FWD;
			idx_q           <= '0;
			cnt_q           <= '0;
			wait_q          <= 1'b0;
			ang_sel_q       <= 1'b0;
			emit_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			start_pitch_q   <= '0;
			start_yaw_q     <= '0;
			start_radius_q  <= 32'sd327680;
			start_pivot_x_q <= '0;
			start_pivot_y_q <= '0;
			start_pivot_z_q <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_PITCH:   start_pitch_q   <= cfg_data;
					CFG_START_YAW:     start_yaw_q     <= cfg_data;
					CFG_START_RADIUS:  start_radius_q  <= cfg_data;
					CFG_START_PIVOT_X: start_pivot_x_q <= cfg_data;
					CFG_START_PIVOT_Y: start_pivot_y_q <= cfg_data;
					CFG_START_PIVOT_Z: start_pivot_z_q <= cfg_data;
					default: ;
				endcase
			end

			// result valid: set on load, cleared when taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			if (mul_go || root_go)
				wait_q <= 1'b1;
			else if (mul_done || root_done)
				wait_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(opcode);
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					idx_q     <= '0;
					cnt_q     <= '0;
					ang_sel_q <= 1'b0;
					state_q   <= (op_q == OP_STRAFE) ? ST_SMUL : ST_RED;
				end
				ST_SMUL: begin
					if (mul_done) begin
						if (idx_q == 3'd5) begin
							idx_q     <= '0;
							cnt_q     <= '0;
							ang_sel_q <= 1'b0;
							state_q   <= ST_RED;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_RED: begin
					if (cnt_q == 5'(RED_STEPS))
						state_q <= ST_FOLD;
					else
						cnt_q <= cnt_q + 5'd1;
				end
				ST_FOLD: begin
					cnt_q   <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
						cnt_q <= '0;
						if (!ang_sel_q) begin
							ang_sel_q <= 1'b1;
							state_q   <= ST_RED;
						end else begin
							idx_q   <= '0;
							state_q <= ST_FMUL;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_FMUL: begin
					if (mul_done) begin
						if (idx_q == 3'd1) begin
							idx_q   <= '0;
							dst_q   <= DST_FWD;
							state_q <= ST_NSQ;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_NSQ: begin
					if (mul_done) begin
						if (idx_q == 3'd2) begin
							idx_q   <= '0;
							state_q <= ST_ROOT;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						idx_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						cnt_q <= '0;
						if (idx_q == 3'd2) begin
							idx_q <= '0;
							case (dst_q)
								DST_FWD: state_q <= ST_PMUL;
								DST_RGT: state_q <= ST_XMUL;
								default: state_q <= ST_DONE;
							endcase
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_PMUL: begin
					if (mul_done) begin
						if (idx_q == 3'd2) begin
							idx_q   <= '0;
							dst_q   <= DST_RGT;
							state_q <= ST_NSQ;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_XMUL: begin
					if (mul_done) begin
						if (idx_q == 3'd5) begin
							idx_q   <= '0;
							dst_q   <= DST_UP;
							state_q <= ST_NSQ;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_DONE: begin
					if (!emit_q) begin
						emit_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					delta_a_q <= delta_a;
					delta_b_q <= delta_b;
				end
			end
			ST_APPLY: begin
				case (op_q)
					OP_ROTATE: begin
						pitch_q <= sat32(40'(pitch_q) - 40'(delta_b_q));
						yaw_q   <= sat32(40'(yaw_q) + 40'(delta_a_q));
					end
					OP_RADIUS: radius_q <= sat32(40'(radius_q) + 40'(delta_a_q));
					OP_RESTART: begin
						pitch_q  <= start_pitch_q;
						yaw_q    <= start_yaw_q;
						radius_q <= start_radius_q;
						piv_q[0] <= start_pivot_x_q;
						piv_q[1] <= start_pivot_y_q;
						piv_q[2] <= start_pivot_z_q;
					end
					default: ;
				endcase
			end
			ST_SMUL: begin
				if (mul_done) begin
					if (!idx_q[0])
						p1_q <= prod;
					else
						piv_q[vi] <= piv_str;
				end
			end
			ST_RED: begin
				if (cnt_q == 5'd0) begin
					aneg_q <= ang[31];
					m_q    <= RW'(mag(MW'(ang)));
					dv_q   <= FULL_TURN << (RED_STEPS - 1);
				end else begin
					if (m_q >= dv_q)
						m_q <= m_q - dv_q;
					dv_q <= dv_q >> 1;
				end
			end
			ST_FOLD: begin
				x_q <= CORDIC_X0;
				y_q <= '0;
				if ((z0 > D90) && (z0 <= D270)) begin
					z_q    <= z0 - D180;
					fneg_q <= 1'b1;
				end else if (z0 > D270) begin
					z_q    <= z0 - D360;
					fneg_q <= 1'b0;
				end else begin
					z_q    <= z0;
					fneg_q <= 1'b0;
				end
			end
			ST_CORD: begin
				x_q <= nx;
				y_q <= ny;
				z_q <= nz;
				if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
					if (!ang_sel_q) begin
						cy_q <= fneg_q ? -nx : nx;
						sy_q <= fneg_q ? -ny : ny;
					end else begin
						cp_q <= fneg_q ? -nx : nx;
						sp_q <= fneg_q ? -ny : ny;
					end
				end
			end
			ST_FMUL: begin
				if (mul_done) begin
					if (!idx_q[0]) begin
						v_q[0] <= raw_new;
					end else begin
						v_q[2] <= raw_new;
						v_q[1] <= sp_q;
					end
				end
			end
			ST_NSQ: begin
				if (mul_done)
					sum_q <= ((idx_q == 3'd0) ? 64'd0 : sum_q) + prod[63:0];
			end
			ST_ROOT: begin
				if (root_done)
					len_q <= root;
			end
			ST_DIV: begin
				if (cnt_q == 5'd0) begin
					dr_q  <= div_n[47:QW];
					dn_q  <= div_n[QW-1:0];
					quo_q <= '0;
				end else begin
					dr_q  <= div_ge ? div_t - {1'b0, len_q} : div_t;
					dn_q  <= {dn_q[QW-2:0], 1'b0};
					quo_q <= quo_next;
				end
				if (div_last) begin
					case (dst_q)
						DST_FWD: fwd_q[vi] <= div_res;
						DST_RGT: rgt_q[vi] <= div_res;
						default: up_q[vi]  <= div_res;
					endcase
				end
			end
			ST_PMUL: begin
				if (mul_done) begin
					pos_q[vi] <= pos_new;
					if (idx_q == 3'd2) begin
						v_q[0] <= -VW'(fwd_q[2]);
						v_q[1] <= '0;
						v_q[2] <= VW'(fwd_q[0]);
					end
				end
			end
			ST_XMUL: begin
				if (mul_done) begin
					if (!idx_q[0])
						p1_q <= prod;
					else
						v_q[vi] <= VW'(p1_q - prod);
				end
			end
			default: ;
		endcase

		// result register
		if (out_load) begin
			out_pos_q <= pos_q;
			out_fwd_q <= fwd_q;
			out_rgt_q <= rgt_q;
			out_up_q  <= up_q;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign position_x = out_pos_q[0];
	assign position_y = out_pos_q[1];
	assign position_z = out_pos_q[2];
	assign forward_x  = out_fwd_q[0];
	assign forward_y  = out_fwd_q[1];
	assign forward_z  = out_fwd_q[2];
	assign right_x    = out_rgt_q[0];
	assign right_y    = out_rgt_q[1];
	assign right_z    = out_rgt_q[2];
	assign up_x       = out_up_q[0];
	assign up_y       = out_up_q[1];
	assign up_z       = out_up_q[2];

endmodule

// File: tb/orbit_camera_update_top_test.sv
// testbench for orbit_camera_update_top: directed, configuration, stall, no-idle and random item tests
// depends on ocu_pkg and the orbit_camera_update_top rtl; predicts each camera view itself
module orbit_camera_update_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ocu_pkg::*;

	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 1500;

	typedef longint vec3_t [3];

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [15:0] fwd [3];
		logic signed [15:0] rgt [3];
		logic signed [15:0] upv [3];
	} view_t;

	// atan(2^-i) in degrees with 24 fraction bits
	localparam longint ATAN_TAB [16] = '{754974720, 445687602, 235489088, 119537938,
		60000934, 30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335};

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	logic [1:0] opcode;
	logic signed [31:0] delta_a, delta_b;
	logic out_valid, out_ready;
	logic signed [31:0] position_x, position_y, position_z;
	logic signed [15:0] forward_x, forward_y, forward_z;
	logic signed [15:0] right_x, right_y, right_z;
	logic signed [15:0] up_x, up_y, up_z;

	orbit_camera_update_top dut (.*);

	// camera model state
	longint start_regs [6];
	longint cam_pitch, cam_yaw, cam_radius;
	vec3_t cam_pivot, cam_right, cam_up;

	view_t pending_views [$];
	int errors = 0;
	int views_checked = 0;
	int items_sent = 0;
	int config_writes = 0;
	longint cycles = 0;

	// receiver control
	bit rx_quiet = 0;
	int hold_req_seq = 0;
	int hold_req_cycles = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[orbit_camera_update_top] ERROR");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic vec3_t unit_q14(vec3_t v);
		longint unsigned m [3];
		longint unsigned total, len, q;
		vec3_t o;
		total = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			total += m[i] * m[i];
		end
		len = int_sqrt(total);
		for (int i = 0; i < 3; i++) begin
			if (len == 0)
				o[i] = 0;
			else begin
				q = (m[i] * 16384 + len / 2) / len;
				o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
			end
		end
		return o;
	endfunction

	// cordic cosine and sine of an angle in degrees, Q1.30
	task automatic trig_deg(input longint ang, output longint c, output longint s);
		longint full, d90, z, x, y, dx, dy;
		bit flip;
		full = 64'sd360 <<< FRACTION_BITS;
		d90 = 64'sd90 <<< ANG_FRAC;
		x = 652032874;
		y = 0;
		flip = 0;
		z = ang % full;
		if (z < 0) z += full;
		z = z <<< (ANG_FRAC - FRACTION_BITS);
		if (z > d90 && z <= 3 * d90) begin
			z -= 2 * d90;
			flip = 1;
		end else if (z > 3 * d90)
			z -= 4 * d90;
		for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// forward, position, right and up from the current camera state
	task automatic derive_view(output view_t v);
		longint cy, sy, cp, sp;
		vec3_t raw, fw, cr;
		trig_deg(cam_yaw, cy, sy);
		trig_deg(cam_pitch, cp, sp);
		raw[0] = round_shift(cy * cp, 30);
		raw[1] = sp;
		raw[2] = round_shift(sy * cp, 30);
		fw = unit_q14(raw);
		for (int i = 0; i < 3; i++)
			v.pos[i] = 32'(clamp32(cam_pivot[i] - round_shift(fw[i] * cam_radius, 14)));
		cr[0] = -fw[2];
		cr[1] = 0;
		cr[2] = fw[0];
		cam_right = unit_q14(cr);
		cr[0] = cam_right[1] * fw[2] - cam_right[2] * fw[1];
		cr[1] = cam_right[2] * fw[0] - cam_right[0] * fw[2];
		cr[2] = cam_right[0] * fw[1] - cam_right[1] * fw[0];
		cam_up = unit_q14(cr);
		for (int i = 0; i < 3; i++) begin
			v.fwd[i] = 16'(fw[i]);
			v.rgt[i] = 16'(cam_right[i]);
			v.upv[i] = 16'(cam_up[i]);
		end
	endtask

	task automatic load_start();
		view_t unused;
		cam_pitch = start_regs[CFG_START_PITCH];
		cam_yaw = start_regs[CFG_START_YAW];
		cam_radius = start_regs[CFG_START_RADIUS];
		cam_pivot[0] = start_regs[CFG_START_PIVOT_X];
		cam_pivot[1] = start_regs[CFG_START_PIVOT_Y];
		cam_pivot[2] = start_regs[CFG_START_PIVOT_Z];
		derive_view(unused);
	endtask

	// apply one accepted item and queue the view it produces
	task automatic predict_camera(op_t op, longint a, longint b);
		view_t v;
		case (op)
			OP_ROTATE: begin
				cam_pitch = clamp32(cam_pitch - b);
				cam_yaw = clamp32(cam_yaw + a);
			end
			OP_STRAFE:
				for (int i = 0; i < 3; i++)
					cam_pivot[i] = clamp32(cam_pivot[i]
						+ round_shift(-a * cam_right[i] + b * cam_up[i], 14));
			OP_RADIUS: cam_radius = clamp32(cam_radius + a);
			default: begin
				cam_pitch = start_regs[CFG_START_PITCH];
				cam_yaw = start_regs[CFG_START_YAW];
				cam_radius = start_regs[CFG_START_RADIUS];
				cam_pivot[0] = start_regs[CFG_START_PIVOT_X];
				cam_pivot[1] = start_regs[CFG_START_PIVOT_Y];
				cam_pivot[2] = start_regs[CFG_START_PIVOT_Z];
			end
		endcase
		derive_view(v);
		pending_views.push_back(v);
	endtask

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// check each result item against the oldest predicted view
	always @(posedge clk) begin
		view_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_views.size() == 0)
				report("unexpected item", 0, 0);
			else begin
				w = pending_views.pop_front();
				if (position_x !== w.pos[0]) report("position_x", position_x, w.pos[0]);
				if (position_y !== w.pos[1]) report("position_y", position_y, w.pos[1]);
				if (position_z !== w.pos[2]) report("position_z", position_z, w.pos[2]);
				if (forward_x !== w.fwd[0]) report("forward_x", forward_x, w.fwd[0]);
				if (forward_y !== w.fwd[1]) report("forward_y", forward_y, w.fwd[1]);
				if (forward_z !== w.fwd[2]) report("forward_z", forward_z, w.fwd[2]);
				if (right_x !== w.rgt[0]) report("right_x", right_x, w.rgt[0]);
				if (right_y !== w.rgt[1]) report("right_y", right_y, w.rgt[1]);
				if (right_z !== w.rgt[2]) report("right_z", right_z, w.rgt[2]);
				if (up_x !== w.upv[0]) report("up_x", up_x, w.upv[0]);
				if (up_y !== w.upv[1]) report("up_y", up_y, w.upv[1]);
				if (up_z !== w.upv[2]) report("up_z", up_z, w.upv[2]);
			end
			views_checked <= views_checked + 1;
		end
	end

	// receiver: random gap per item, plus requested long hold-offs
	initial begin
		int seen, gap, hold, hold_seq;
		seen = 0;
		gap = 0;
		hold = 0;
		hold_seq = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_req_seq) begin
				hold_seq = hold_req_seq;
				hold = hold_req_cycles;
			end
			if (seen != views_checked) begin
				seen = views_checked;
				gap = rx_quiet ? 0 : $urandom_range(0, 13);
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 0;
			end else if (gap > 0) begin
				gap--;
				out_ready <= 0;
			end else
				out_ready <= 1;
		end
	end

	// send one item after a random gap, unless no_gap is set, and predict it on acceptance
	task automatic send_item(op_t op, logic [31:0] a, logic [31:0] b, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		opcode <= op;
		delta_a <= a;
		delta_b <= b;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_camera(op, longint'($signed(a)), longint'($signed(b)));
		items_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic wait_drained();
		go_idle();
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx < 6) start_regs[idx] = longint'($signed(val));
		config_writes++;
	endtask

	function automatic logic [31:0] rand_delta();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 720 << 16)) - (360 << 16));
		endcase
	endfunction

	// extremes of the fields, every operation, pitch at the poles, saturation
	task automatic test_directed();
		send_item(OP_ROTATE, 0, 0);
		send_item(OP_ROTATE, 32'(90 << 16), 0);
		send_item(OP_ROTATE, 0, -32'sd5898240);
		send_item(OP_STRAFE, 32'(3 << 16), 32'(2 << 16));
		send_item(OP_ROTATE, 0, 32'(180 << 16));
		send_item(OP_RESTART, 32'hffffffff, 32'hffffffff);
		send_item(OP_ROTATE, 32'h7fffffff, 32'h80000000);
		send_item(OP_ROTATE, 32'h7fffffff, 32'h80000000);
		send_item(OP_ROTATE, 32'h80000000, 32'h7fffffff);
		send_item(OP_RESTART, 0, 0);
		send_item(OP_STRAFE, 32'h7fffffff, 32'h80000000);
		send_item(OP_STRAFE, 32'h7fffffff, 32'h80000000);
		send_item(OP_STRAFE, 32'h80000000, 32'h7fffffff);
		send_item(OP_RADIUS, -32'sd655360, 0);
		send_item(OP_RADIUS, -32'sd655360, 32'hffffffff);
		send_item(OP_RADIUS, 32'h7fffffff, 0);
		send_item(OP_RADIUS, 32'h7fffffff, 0);
		send_item(OP_RADIUS, 32'h80000000, 0);
		send_item(OP_RADIUS, 32'h80000000, 0);
		send_item(OP_RESTART, 32'h5555aaaa, 32'haaaa5555);
		wait_drained();
	endtask

	// start registers at their extremes, plus writes to unused indexes
	task automatic test_config_extremes();
		logic [31:0] ext [3];
		ext = '{32'h7fffffff, 32'h80000000, 32'h0};
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 6; r++)
				cfg_write(3'(r), ext[(k + r) % 3]);
			cfg_write(3'd6, $urandom());
			cfg_write(3'd7, $urandom());
			send_item(OP_RESTART, 0, 0);
			send_item(OP_ROTATE, 32'(45 << 16), 32'(30 << 16));
			send_item(OP_STRAFE, 32'(1 << 16), -32'sd65536);
			send_item(OP_RADIUS, 32'(7 << 16), 0);
			wait_drained();
		end
	endtask

	// mostly rotate, strafe and radius runs with occasional restarts
	task automatic test_random(int count);
		op_t op;
		for (int r = 0; r < 6; r++)
			cfg_write(3'(r), rand_delta());
		send_item(OP_RESTART, $urandom(), $urandom());
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(0, 15) == 0) ? OP_RESTART : op_t'($urandom_range(0, 2));
			send_item(op, rand_delta(), rand_delta(), $urandom_range(0, 3) == 0);
		end
		wait_drained();
	endtask

	// receiver holds off while items keep coming, so the input stalls
	task automatic test_backpressure();
		hold_req_cycles = 6000;
		hold_req_seq++;
		for (int n = 0; n < 6; n++)
			send_item(op_t'($urandom_range(0, 3)), rand_delta(), rand_delta(), 1);
		wait_drained();
	endtask

	// back-to-back items with no idling on either side
	task automatic test_no_idle();
		rx_quiet = 1;
		for (int n = 0; n < 40; n++)
			send_item(op_t'($urandom_range(0, 3)), rand_delta(), rand_delta(), 1);
		wait_drained();
		rx_quiet = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		opcode = '0;
		delta_a = '0;
		delta_b = '0;
		start_regs = '{0, 0, 327680, 0, 0, 0};
		load_start();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// block runs its restart pass before taking items
		@(posedge clk);
		while (!in_ready) @(posedge clk);

		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random(330);
		test_no_idle();
		test_random(330);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items, %0d results checked, %0d register writes",
			items_sent, views_checked, config_writes);
		$display("included pole pitch, saturation, negative radius and a long output stall");
		if (errors == 0 && pending_views.size() == 0)
			$display("[orbit_camera_update_top] OK");
		else
			$display("[orbit_camera_update_top] ERROR");
		$finish;
	end

endmodule
